// ----- hw/rtl/hrphc_pkg.sv -----
// Shared types, constants and the FNV-1a mixing function for the path hash classifier.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package hrphc_pkg;

  // Message checks
  localparam int unsigned URI_MAX      = 64;   // longest HTTP/1 path that is hashed
  localparam int unsigned H2_BLOCK_MAX = 128;  // longest HEADERS frame accepted
  localparam int unsigned HEAD_DEPTH   = 14;   // leading bytes kept per message
  localparam int unsigned HEAD_IDX_W   = 4;
  localparam int unsigned POS_W        = 8;    // saturating byte position
  localparam int unsigned LEN_W        = 9;    // message length, 1..256

  // FNV-1a 64; the prime is 2^40 + 0x1b3
  localparam logic [63:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;

  // Byte codes
  localparam logic [7:0] CHAR_SPACE      = 8'h20;
  localparam logic [7:0] CHAR_CR         = 8'h0d;
  localparam logic [7:0] CHAR_LF         = 8'h0a;
  localparam logic [7:0] CHAR_G          = 8'h47;
  localparam logic [7:0] CHAR_E          = 8'h45;
  localparam logic [7:0] CHAR_T          = 8'h54;
  localparam logic [7:0] CHAR_SLASH      = 8'h2f;
  localparam logic [7:0] H2_TYPE_HEADERS = 8'h01;
  localparam logic [7:0] H2_FLAG_MASK    = 8'h28;  // PADDED | PRIORITY
  localparam logic [7:0] HPACK_GET       = 8'h82;  // indexed :method GET
  localparam logic [7:0] HPACK_PATH_ROOT = 8'h84;  // indexed :path /
  localparam logic [5:0] HPACK_PATH_NAME = 6'd4;   // static table index of :path

  typedef logic [HEAD_DEPTH-1:0][7:0] head_t;

  // Connection preface, byte 0 in the lowest lane
  localparam head_t PREFACE_TEXT = "0.2/PTTH * IRP";

  typedef enum logic [2:0] {
    VerdictMalformed  = 3'd0,
    VerdictPreface    = 3'd1,
    VerdictHpackUnsup = 3'd2,
    VerdictNonHttp    = 3'd3,
    VerdictH2Path     = 3'd4,
    VerdictHttp1Get   = 3'd5
  } verdict_e;

  typedef enum logic [1:0] {
    PhaseNone  = 2'd0,
    PhaseHttp1 = 2'd1,
    PhaseHttp2 = 2'd2
  } phase_e;

  // One registered input byte
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic [31:0] conn_key;
  } item_t;

  // Message view after the current byte is folded in
  typedef struct packed {
    logic [LEN_W-1:0] len;
    head_t            head;
    logic [63:0]      hash;
    logic [31:0]      conn_key;
  } view_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [63:0] uri_hash;
    logic        stream_check;
    logic [30:0] stream_number;
    logic [31:0] connection_key;
  } result_t;

  function automatic logic [63:0] fnv_mix(logic [63:0] h, logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

  localparam logic [63:0] FNV_SLASH = fnv_mix(FNV_BASIS, CHAR_SLASH);

endpackage

// ----- hw/rtl/hrphc_in_stage.sv -----
// Input register of the classifier: holds one byte transfer and its folded connection key.
// Depends on hrphc_pkg.
`timescale 1ns / 1ps

module hrphc_in_stage import hrphc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [31:0] remote_addr_i,
  input  logic [31:0] local_addr_i,
  input  logic [31:0] remote_port_word_i,
  input  logic [31:0] local_port_word_i,
  input  logic        take_i,
  output logic        valid_o,
  output item_t       item_o
);

  logic  valid_q, valid_d;
  logic  load;
  item_t item_q;

  assign ready_o = !valid_q || take_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.data     <= data_byte_i;
      item_q.last     <= last_byte_i;
      item_q.conn_key <= remote_addr_i ^ local_addr_i ^ remote_port_word_i ^ local_port_word_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- hw/rtl/hrphc_tracker.sv -----
// Per-message state: byte position, leading bytes, parse phase and running FNV-1a hash.
// Depends on hrphc_pkg.
`timescale 1ns / 1ps

module hrphc_tracker import hrphc_pkg::*; #(
  parameter int unsigned URI_LIMIT = URI_MAX
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  fire_i,
  input  item_t item_i,
  output view_t view_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  head_t            head_q, head_d;
  logic [63:0]      hash_q, hash_d;
  phase_e           phase_q, phase_d;
  logic [6:0]       vlen_q, vlen_d;
  logic             stopped_q, stopped_d;
  logic [31:0]      key_q, key_d;
  logic [LEN_W-1:0] pos_ext;
  logic             in_uri, in_value, uri_end;

  assign pos_ext = {1'b0, pos_q};

  always_comb begin
    head_d = head_q;
    if (pos_q < POS_W'(HEAD_DEPTH)) begin
      head_d[pos_q[HEAD_IDX_W-1:0]] = item_i.data;
    end

    phase_d = phase_q;
    if (pos_q == POS_W'(3)) begin
      if (item_i.data == CHAR_SPACE) begin
        phase_d = PhaseHttp1;
      end else if (item_i.data == H2_TYPE_HEADERS) begin
        phase_d = PhaseHttp2;
      end else begin
        phase_d = PhaseNone;
      end
    end

    vlen_d = (pos_q == POS_W'(11)) ? item_i.data[6:0] : vlen_q;
    key_d  = (pos_q == '0) ? item_i.conn_key : key_q;

    // HTTP/1 path runs from byte 4 up to a delimiter; HTTP/2 value from byte 12
    in_uri   = (phase_q == PhaseHttp1) && (pos_q >= POS_W'(4)) &&
               (pos_ext < LEN_W'(4 + URI_LIMIT)) && !stopped_q;
    in_value = (phase_q == PhaseHttp2) && (pos_q >= POS_W'(12)) &&
               (pos_ext < LEN_W'(12) + LEN_W'(vlen_q));
    uri_end  = (item_i.data == CHAR_SPACE) || (item_i.data == CHAR_CR) ||
               (item_i.data == CHAR_LF);

    hash_d    = hash_q;
    stopped_d = stopped_q;
    if (in_uri) begin
      if (uri_end) begin
        stopped_d = 1'b1;
      end else begin
        hash_d = fnv_mix(hash_q, item_i.data);
      end
    end else if (in_value) begin
      hash_d = fnv_mix(hash_q, item_i.data);
    end

    pos_d = (pos_q == '1) ? pos_q : pos_q + POS_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      hash_q    <= FNV_BASIS;
      phase_q   <= PhaseNone;
      vlen_q    <= '0;
      stopped_q <= 1'b0;
      key_q     <= '0;
    end else if (fire_i) begin
      if (item_i.last) begin
        // message done: return to start-of-message state
        pos_q     <= '0;
        hash_q    <= FNV_BASIS;
        phase_q   <= PhaseNone;
        vlen_q    <= '0;
        stopped_q <= 1'b0;
        key_q     <= '0;
      end else begin
        pos_q     <= pos_d;
        hash_q    <= hash_d;
        phase_q   <= phase_d;
        vlen_q    <= vlen_d;
        stopped_q <= stopped_d;
        key_q     <= key_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      head_q <= head_d;
    end
  end

  assign view_o.len      = pos_ext + LEN_W'(1);
  assign view_o.head     = head_d;
  assign view_o.hash     = hash_d;
  assign view_o.conn_key = key_d;

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && item_i.last |=> pos_q == '0 && hash_q == FNV_BASIS && !stopped_q)
    else $error("tracker state not cleared after last byte");

  a_stop_only_http1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |-> phase_q == PhaseHttp1)
    else $error("path hash stopped outside an HTTP/1 message");

  a_vlen_late: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vlen_q != '0 |-> pos_q >= POS_W'(12))
    else $error("value length set before byte 11 was seen");

endmodule

// ----- hw/rtl/hrphc_classify.sv -----
// Message classifier: turns the final message view into a verdict, path hash and stream key.
// Depends on hrphc_pkg; purely combinational.
`timescale 1ns / 1ps

module hrphc_classify import hrphc_pkg::*; #(
  parameter int unsigned URI_LIMIT   = URI_MAX,
  parameter int unsigned BLOCK_LIMIT = H2_BLOCK_MAX
) (
  input  view_t   view_i,
  output result_t result_o
);

  head_t       h;
  logic [23:0] blk_len;
  logic [30:0] sid;
  logic [9:0]  len_w;
  logic [9:0]  blk_end;
  logic [9:0]  value_end;
  logic        name_is_path;

  assign h         = view_i.head;
  assign blk_len   = {h[0], h[1], h[2]};
  assign sid       = {h[5][6:0], h[6], h[7], h[8]};
  assign len_w     = {1'b0, view_i.len};
  assign blk_end   = 10'd9 + {2'b0, blk_len[7:0]};
  assign value_end = 10'd12 + {3'b0, h[11][6:0]};
  // literal with incremental indexing, without indexing or never indexed, name index :path
  assign name_is_path = ((h[10][7:6] == 2'b01) && (h[10][5:0] == HPACK_PATH_NAME)) ||
                        ((h[10][7:5] == 3'b000) && (h[10][3:0] == HPACK_PATH_NAME[3:0]));

  always_comb begin
    result_o = '0;
    result_o.verdict = VerdictMalformed;
    if ((view_i.len >= LEN_W'(HEAD_DEPTH)) && (h == PREFACE_TEXT)) begin
      result_o.verdict = VerdictPreface;
    end else begin
      if ((view_i.len >= LEN_W'(9)) && (sid != '0)) begin
        result_o.stream_check   = 1'b1;
        result_o.stream_number  = sid;
        result_o.connection_key = view_i.conn_key;
      end
      if ((view_i.len < LEN_W'(9)) || (h[3] != H2_TYPE_HEADERS)) begin
        if (view_i.len < LEN_W'(5)) begin
          result_o.verdict = VerdictMalformed;
        end else if ((h[0] != CHAR_G) || (h[1] != CHAR_E) || (h[2] != CHAR_T) ||
                     (h[3] != CHAR_SPACE)) begin
          result_o.verdict = VerdictNonHttp;
        end else begin
          result_o.verdict  = VerdictHttp1Get;
          result_o.uri_hash = view_i.hash;
        end
      end else if ((blk_len == '0) || (blk_len > 24'(BLOCK_LIMIT))) begin
        result_o.verdict = VerdictHpackUnsup;
      end else if (len_w < blk_end) begin
        result_o.verdict = VerdictMalformed;
      end else if ((h[4] & H2_FLAG_MASK) != '0) begin
        result_o.verdict = VerdictHpackUnsup;
      end else if (view_i.len < LEN_W'(10)) begin
        result_o.verdict = VerdictMalformed;
      end else if (h[9] != HPACK_GET) begin
        result_o.verdict = VerdictNonHttp;
      end else if (view_i.len < LEN_W'(11)) begin
        result_o.verdict = VerdictMalformed;
      end else if (h[10] == HPACK_PATH_ROOT) begin
        result_o.verdict  = VerdictH2Path;
        result_o.uri_hash = FNV_SLASH;
      end else if (!name_is_path) begin
        result_o.verdict = VerdictHpackUnsup;
      end else if (view_i.len < LEN_W'(12)) begin
        result_o.verdict = VerdictMalformed;
      end else if (h[11][7] || (h[11][6:0] > 7'(URI_LIMIT))) begin
        result_o.verdict = VerdictHpackUnsup;
      end else if (len_w < value_end) begin
        result_o.verdict = VerdictMalformed;
      end else begin
        result_o.verdict  = VerdictH2Path;
        result_o.uri_hash = view_i.hash;
      end
    end
  end

endmodule

// ----- hw/rtl/http_request_path_hash_classifier_unit.sv -----
// Path hash classifier top level: byte stream in, one verdict transfer per message out.
// A message's last byte passes the input register, then the result register.
// Throughput: one byte per cycle (FNV-1a shift-add and classifier are combinational); a last
// byte waits in the input register while the previous verdict is still not taken.
// Reset (rst_ni, async, active low) empties both registers and returns to start of message.
// Depends on hrphc_pkg, hrphc_in_stage, hrphc_tracker and hrphc_classify.
`timescale 1ns / 1ps

module http_request_path_hash_classifier_unit import hrphc_pkg::*; #(
  parameter int unsigned URI_LIMIT   = URI_MAX,
  parameter int unsigned BLOCK_LIMIT = H2_BLOCK_MAX
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // byte stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [7:0] data_byte, [39:8] remote_addr, [71:40] local_addr,
  // [103:72] remote_port_word, [135:104] local_port_word
  input  logic [135:0] s_axis_tdata,
  input  logic         s_axis_tlast,   // last_byte
  // verdict stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [2:0] verdict_class, [66:3] uri_hash, [67] stream_check,
  // [98:68] stream_number, [130:99] connection_key, [135:131] zero
  output logic [135:0] m_axis_tdata
);

  logic    in_valid;
  item_t   in_item;
  logic    out_free;
  logic    fire;
  view_t   view;
  result_t result;
  logic    res_valid_q, res_valid_d;
  result_t res_q;
  logic [2:0] verdict_bits;

  // Input register; the xor connection key is folded here
  hrphc_in_stage u_in_stage (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .valid_i            (s_axis_tvalid),
    .ready_o            (s_axis_tready),
    .data_byte_i        (s_axis_tdata[7:0]),
    .last_byte_i        (s_axis_tlast),
    .remote_addr_i      (s_axis_tdata[39:8]),
    .local_addr_i       (s_axis_tdata[71:40]),
    .remote_port_word_i (s_axis_tdata[103:72]),
    .local_port_word_i  (s_axis_tdata[135:104]),
    .take_i             (fire),
    .valid_o            (in_valid),
    .item_o             (in_item)
  );

  // Advance a byte when it produces no result, or when the result slot is free
  // (empty now or draining this cycle).
  assign out_free = !res_valid_q || m_axis_tready;
  assign fire     = in_valid && (!in_item.last || out_free);

  hrphc_tracker #(
    .URI_LIMIT (URI_LIMIT)
  ) u_tracker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_item),
    .view_o (view)
  );

  hrphc_classify #(
    .URI_LIMIT   (URI_LIMIT),
    .BLOCK_LIMIT (BLOCK_LIMIT)
  ) u_classify (
    .view_i   (view),
    .result_o (result)
  );

  // Result register: load on the last byte, drop once the transfer completes
  always_comb begin
    res_valid_d = res_valid_q;
    if (fire && in_item.last) begin
      res_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && in_item.last) begin
      res_q <= result;
    end
  end

  assign verdict_bits  = res_q.verdict;
  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = {5'd0, res_q.connection_key, res_q.stream_number,
                          res_q.stream_check, res_q.uri_hash, verdict_bits};

  a_hash_only_paths: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && (res_q.verdict != VerdictH2Path) && (res_q.verdict != VerdictHttp1Get)
      |-> res_q.uri_hash == '0)
    else $error("path hash set for a class without a path");

  a_stream_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_q.stream_check
      |-> res_q.stream_number == '0 && res_q.connection_key == '0)
    else $error("stream fields set without stream check");

  a_preface_no_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && (res_q.verdict == VerdictPreface) |-> !res_q.stream_check)
    else $error("stream check raised on connection preface");

endmodule
